>>> rtl/irpwfd_pkg.sv
// Shared types and constants for the IR pulse-width frame decoder.
// Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps

package irpwfd_pkg;

  localparam int DUR_W  = 16;
  localparam int CODE_W = 20;
  localparam int CNT_W  = 5;
  localparam int TOL_W  = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  localparam int DURATION_BITS_DEF = 16;

  // nominal pulse lengths in us
  localparam int NOM_HDR_MARK_US = 2400;
  localparam int NOM_SHORT_US    = 600;
  localparam int NOM_LONG_US     = 1200;

  localparam logic [CNT_W-1:0] BITS_MAX = 5'd20;
  localparam logic [CNT_W-1:0] BITS_12  = 5'd12;
  localparam logic [CNT_W-1:0] BITS_15  = 5'd15;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_COUNT = 2'd2;

  localparam logic [TOL_W-1:0]  TOL_RESET = 7'd25;
  localparam logic [CODE_W-1:0] MATCH_CODE_RESET = '0;
  localparam logic [CNT_W-1:0]  MATCH_COUNT_RESET = 5'd12;

  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] duration_us;
    logic             burst_end;
  } in_word_t;

  typedef struct packed {
    logic              frame_valid;
    logic [CODE_W-1:0] code;
    logic [CNT_W-1:0]  bit_count;
    logic              matched;
  } out_word_t;

  // duration window hits for the current pulse
  typedef struct packed {
    logic hdr_ok;      // within 2400 us window
    logic short_ok;    // within 600 us window
    logic long_ok;     // within 1200 us window
    logic above_short; // at or above lower edge of 600 us window
  } win_t;

endpackage

>>> rtl/irpwfd_window.sv
// Duration window compare: checks one pulse length against the nominal
// windows set by the tolerance register. Depends on irpwfd_pkg.
`timescale 1ns / 1ps

module irpwfd_window #(
  parameter int DURATION_BITS = irpwfd_pkg::DURATION_BITS_DEF
) (
  input  logic [irpwfd_pkg::DUR_W-1:0] duration_us,
  input  logic [irpwfd_pkg::TOL_W-1:0] tol,
  output irpwfd_pkg::win_t             win
);

  localparam int W = irpwfd_pkg::DUR_W;
  localparam int KEEP = (DURATION_BITS < W) ? DURATION_BITS : W;
  localparam logic [W-1:0] DUR_MASK = W'((33'(1) << KEEP) - 33'(1));

  // all nominals are whole multiples of 100 us, so n*(100+-tol)/100 is exact
  localparam logic [W-1:0] HDR_STEP   = W'(irpwfd_pkg::NOM_HDR_MARK_US / 100);
  localparam logic [W-1:0] SHORT_STEP = W'(irpwfd_pkg::NOM_SHORT_US / 100);
  localparam logic [W-1:0] LONG_STEP  = W'(irpwfd_pkg::NOM_LONG_US / 100);

  logic [W-1:0] d;
  logic [7:0]   lo_pct;
  logic [7:0]   hi_pct;
  logic [W-1:0] hdr_lo, hdr_hi, short_lo, short_hi, long_lo, long_hi;

  always_comb begin
    d = duration_us & DUR_MASK;
    lo_pct = (tol >= 7'd100) ? 8'd0 : (8'd100 - {1'b0, tol});
    hi_pct = 8'd100 + {1'b0, tol};
    hdr_lo   = W'(lo_pct) * HDR_STEP;
    hdr_hi   = W'(hi_pct) * HDR_STEP;
    short_lo = W'(lo_pct) * SHORT_STEP;
    short_hi = W'(hi_pct) * SHORT_STEP;
    long_lo  = W'(lo_pct) * LONG_STEP;
    long_hi  = W'(hi_pct) * LONG_STEP;

    win.hdr_ok      = (d >= hdr_lo) && (d <= hdr_hi);
    win.short_ok    = (d >= short_lo) && (d <= short_hi);
    win.long_ok     = (d >= long_lo) && (d <= long_hi);
    win.above_short = (d >= short_lo);
  end

endmodule

>>> rtl/irpwfd_core.sv
// Frame state machine: header check, bit shifting, end-of-frame rules and
// per-burst result. Depends on irpwfd_pkg.
`timescale 1ns / 1ps

module irpwfd_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          level,
  input  logic                          burst_end,
  input  irpwfd_pkg::win_t              win,
  input  logic [irpwfd_pkg::CODE_W-1:0] match_code,
  input  logic [irpwfd_pkg::CNT_W-1:0]  match_count,
  output logic                          res_valid,
  output irpwfd_pkg::out_word_t         res
);

  localparam logic [2:0] PH_HDR_MARK  = 3'd0;
  localparam logic [2:0] PH_HDR_SPACE = 3'd1;
  localparam logic [2:0] PH_BIT_MARK  = 3'd2;
  localparam logic [2:0] PH_BIT_SPACE = 3'd3;
  localparam logic [2:0] PH_WAIT      = 3'd4;

  logic [2:0]                      phase_r, phase_nxt;
  logic [irpwfd_pkg::CNT_W-1:0]    bits_r, bits_nxt;
  logic [irpwfd_pkg::CODE_W-1:0]   shift_r, shift_nxt;

  logic [2:0]                      ph_n;
  logic [irpwfd_pkg::CNT_W-1:0]    bits_n;
  logic [irpwfd_pkg::CODE_W-1:0]   shift_n;
  logic                            decided;
  logic                            valid;

  always_comb begin
    ph_n    = phase_r;
    bits_n  = bits_r;
    shift_n = shift_r;
    decided = 1'b0;
    valid   = 1'b0;

    case (phase_r)
      PH_HDR_MARK: begin
        if (level && win.hdr_ok) ph_n = PH_HDR_SPACE;
        else decided = 1'b1;
      end
      PH_HDR_SPACE: begin
        if (!level && win.short_ok) ph_n = PH_BIT_MARK;
        else decided = 1'b1;
      end
      PH_BIT_MARK: begin
        // long window wins when the two overlap
        if (level && win.long_ok) begin
          shift_n = {shift_r[irpwfd_pkg::CODE_W-2:0], 1'b1};
          ph_n = PH_BIT_SPACE;
        end else if (level && win.short_ok) begin
          shift_n = {shift_r[irpwfd_pkg::CODE_W-2:0], 1'b0};
          ph_n = PH_BIT_SPACE;
        end else begin
          decided = 1'b1;
          valid = bits_r inside {irpwfd_pkg::BITS_12, irpwfd_pkg::BITS_15};
        end
      end
      PH_BIT_SPACE: begin
        if (!level && win.short_ok) begin
          bits_n = bits_r + 5'd1;
          if (bits_n >= irpwfd_pkg::BITS_MAX) begin
            decided = 1'b1;
            valid = 1'b1;
          end else begin
            ph_n = PH_BIT_MARK;
          end
        end else if (!level && win.above_short) begin
          bits_n = bits_r + 5'd1;
          decided = 1'b1;
          valid = bits_n inside {irpwfd_pkg::BITS_12, irpwfd_pkg::BITS_15,
                                 irpwfd_pkg::BITS_MAX};
        end else begin
          decided = 1'b1;
        end
      end
      default: ;  // waiting for burst end, handled below
    endcase

    // burst ended before the frame was decided: end-of-data rule
    if (phase_r != PH_WAIT && !decided && burst_end) begin
      decided = 1'b1;
      if (ph_n == PH_BIT_MARK) begin
        valid = bits_n inside {irpwfd_pkg::BITS_12, irpwfd_pkg::BITS_15};
      end else if (ph_n == PH_BIT_SPACE) begin
        bits_n = bits_n + 5'd1;
        valid = bits_n inside {irpwfd_pkg::BITS_12, irpwfd_pkg::BITS_15,
                               irpwfd_pkg::BITS_MAX};
      end
    end

    res.frame_valid = valid;
    res.code        = shift_n;
    res.bit_count   = bits_n;
    res.matched     = valid && (shift_n == match_code) && (bits_n == match_count);
    res_valid       = step && decided && (phase_r != PH_WAIT);

    phase_nxt = phase_r;
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    if (step) begin
      if (burst_end) begin
        phase_nxt = PH_HDR_MARK;
        bits_nxt  = '0;
        shift_nxt = '0;
      end else if (decided) begin
        phase_nxt = PH_WAIT;
      end else begin
        phase_nxt = ph_n;
        bits_nxt  = bits_n;
        shift_nxt = shift_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR_MARK;
      bits_r  <= '0;
      shift_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      bits_r  <= bits_nxt;
      shift_r <= shift_nxt;
    end
  end

`ifndef SYNTHESIS
  a_burst_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && burst_end |=> phase_r == PH_HDR_MARK && bits_r == '0 && shift_r == '0)
    else $error("state not cleared after burst end");

  a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HDR_MARK || phase_r == PH_HDR_SPACE) |-> bits_r == '0 && shift_r == '0)
    else $error("bits present during header");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bits_r < irpwfd_pkg::BITS_MAX)
    else $error("bit count reached limit while frame open");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.frame_valid |-> (res.bit_count == irpwfd_pkg::BITS_12 ||
      res.bit_count == irpwfd_pkg::BITS_15 || res.bit_count == irpwfd_pkg::BITS_MAX))
    else $error("valid frame with bad bit count");

  a_one_per_burst: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !burst_end |=> phase_r == PH_WAIT)
    else $error("second result possible in same burst");
`endif

endmodule

>>> rtl/ir_pulse_width_frame_decoder_unit.sv
// Top level of the IR pulse-width frame decoder: ports, config registers,
// input and result registers. Depends on irpwfd_pkg, irpwfd_window, irpwfd_core.
`timescale 1ns / 1ps

// Decodes header/bit pulse trains from an IR receiver, one pulse word per
// cycle. Each accepted word is held in an input register, decoded by one
// level of window compares and the frame state machine, and any result lands
// in the output register as the word leaves the input register, which a held
// result can delay. A new word is taken every cycle while the result side is
// ready; a held result stalls intake only once the input register is also
// full. At most one result word is produced per burst; pulses after the
// decision are dropped until burst_end. Config writes take effect on the next
// cycle and must only be issued while idle.

module ir_pulse_width_frame_decoder_unit #(
  parameter int DURATION_BITS = irpwfd_pkg::DURATION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  irpwfd_pkg::in_word_t              in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output irpwfd_pkg::out_word_t             out_data,
  input  logic                              cfg_wr_en,
  input  logic [irpwfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irpwfd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [irpwfd_pkg::TOL_W-1:0]  tol_r, tol_nxt;
  logic [irpwfd_pkg::CODE_W-1:0] mcode_r, mcode_nxt;
  logic [irpwfd_pkg::CNT_W-1:0]  mcount_r, mcount_nxt;

  logic                          s1_valid_r, s1_valid_nxt;
  irpwfd_pkg::in_word_t          s1_data_r;
  logic                          out_valid_r, out_valid_nxt;
  irpwfd_pkg::out_word_t         out_data_r;

  logic                          step;
  irpwfd_pkg::win_t              win;
  logic                          res_valid;
  irpwfd_pkg::out_word_t         res;

  always_comb begin
    tol_nxt    = tol_r;
    mcode_nxt  = mcode_r;
    mcount_nxt = mcount_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        irpwfd_pkg::CFG_TOLERANCE:   tol_nxt = cfg_wdata[irpwfd_pkg::TOL_W-1:0];
        irpwfd_pkg::CFG_MATCH_CODE:  mcode_nxt = cfg_wdata[irpwfd_pkg::CODE_W-1:0];
        irpwfd_pkg::CFG_MATCH_COUNT: mcount_nxt = cfg_wdata[irpwfd_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // the stage-1 word moves on when the result register is free or draining
  assign step     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
    else if (step) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (step) out_valid_nxt = res_valid;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r       <= irpwfd_pkg::TOL_RESET;
      mcode_r     <= irpwfd_pkg::MATCH_CODE_RESET;
      mcount_r    <= irpwfd_pkg::MATCH_COUNT_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      tol_r       <= tol_nxt;
      mcode_r     <= mcode_nxt;
      mcount_r    <= mcount_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_data_r <= in_data;
    if (step && res_valid) out_data_r <= res;
  end

  irpwfd_window #(
    .DURATION_BITS(DURATION_BITS)
  ) u_window (
    .duration_us(s1_data_r.duration_us),
    .tol        (tol_r),
    .win        (win)
  );

  irpwfd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .level      (s1_data_r.level),
    .burst_end  (s1_data_r.burst_end),
    .win        (win),
    .match_code (mcode_r),
    .match_count(mcount_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/tb_ir_pulse_width_frame_decoder_unit.sv
// Self-checking testbench for ir_pulse_width_frame_decoder_unit: directed pulse
// table, then random bursts under several register settings, scored by a model.
// Depends on irpwfd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_ir_pulse_width_frame_decoder_unit;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  localparam int DUR_W      = irpwfd_pkg::DUR_W;
  localparam int CODE_W     = irpwfd_pkg::CODE_W;
  localparam int CNT_W      = irpwfd_pkg::CNT_W;
  localparam int TOL_W      = irpwfd_pkg::TOL_W;
  localparam int CFG_IDX_W  = irpwfd_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = irpwfd_pkg::CFG_DATA_W;

  typedef enum logic [2:0] {
    AWAIT_HDR_MARK,
    AWAIT_HDR_SPACE,
    AWAIT_BIT_MARK,
    AWAIT_BIT_SPACE,
    AWAIT_BURST_END
  } frame_phase_e;

  typedef struct {
    irpwfd_pkg::in_word_t w;
    bit                   zero_result;
  } pulse_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  irpwfd_pkg::in_word_t  in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  irpwfd_pkg::out_word_t out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // decoder model state and its copy of the registers
  frame_phase_e      frame_phase = AWAIT_HDR_MARK;
  logic [CNT_W-1:0]  bits_seen = '0;
  logic [CODE_W-1:0] shift_reg = '0;
  logic              reported = 1'b0;
  logic [TOL_W-1:0]  tol_pct = irpwfd_pkg::TOL_RESET;
  logic [CODE_W-1:0] want_code = irpwfd_pkg::MATCH_CODE_RESET;
  logic [CNT_W-1:0]  want_count = irpwfd_pkg::MATCH_COUNT_RESET;

  irpwfd_pkg::out_word_t pending_frames[$];
  pulse_row_t            pulse_table[$];
  irpwfd_pkg::out_word_t oldest;
  int                    errors = 0;
  int                    pulses_sent = 0;
  int                    cycle_count = 0;
  int                    stall_left = 0;
  bit                    steady = 1'b0;

  ir_pulse_width_frame_decoder_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ir_pulse_width_frame_decoder_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- windows
  function automatic int unsigned lo_edge(input int unsigned nom);
    if (tol_pct >= 7'd100) return 0;
    return nom * (100 - int'(tol_pct)) / 100;
  endfunction

  function automatic int unsigned hi_edge(input int unsigned nom);
    return nom * (100 + int'(tol_pct)) / 100;
  endfunction

  function automatic bit in_window(input int unsigned d, input int unsigned nom);
    return d >= lo_edge(nom) && d <= hi_edge(nom);
  endfunction

  // ---------------------------------------------------------------- model
  function automatic void clear_frame();
    frame_phase = AWAIT_HDR_MARK;
    bits_seen = '0;
    shift_reg = '0;
    reported = 1'b0;
  endfunction

  // Returns 1 when the pulse decides the frame; res then holds the result word.
  function automatic bit decode_pulse(input irpwfd_pkg::in_word_t w,
                                      output irpwfd_pkg::out_word_t res);
    logic        mark;
    logic        decided;
    logic        good;
    int unsigned d;
    mark = w.level;
    d = w.duration_us;
    decided = 1'b0;
    good = 1'b0;
    res = '0;
    if (frame_phase == AWAIT_BURST_END || reported) begin
      if (w.burst_end) clear_frame();
      return 1'b0;
    end
    case (frame_phase)
      AWAIT_HDR_MARK: begin
        if (mark && in_window(d, irpwfd_pkg::NOM_HDR_MARK_US)) frame_phase = AWAIT_HDR_SPACE;
        else decided = 1'b1;
      end
      AWAIT_HDR_SPACE: begin
        if (!mark && in_window(d, irpwfd_pkg::NOM_SHORT_US)) frame_phase = AWAIT_BIT_MARK;
        else decided = 1'b1;
      end
      AWAIT_BIT_MARK: begin
        // long window wins when the two overlap at wide tolerance
        if (mark && in_window(d, irpwfd_pkg::NOM_LONG_US)) begin
          shift_reg = {shift_reg[CODE_W-2:0], 1'b1};
          frame_phase = AWAIT_BIT_SPACE;
        end else if (mark && in_window(d, irpwfd_pkg::NOM_SHORT_US)) begin
          shift_reg = {shift_reg[CODE_W-2:0], 1'b0};
          frame_phase = AWAIT_BIT_SPACE;
        end else begin
          decided = 1'b1;
          good = (bits_seen == irpwfd_pkg::BITS_12) || (bits_seen == irpwfd_pkg::BITS_15);
        end
      end
      default: begin
        if (!mark && in_window(d, irpwfd_pkg::NOM_SHORT_US)) begin
          bits_seen = bits_seen + 1'b1;
          if (bits_seen >= irpwfd_pkg::BITS_MAX) begin
            decided = 1'b1;
            good = 1'b1;
          end else begin
            frame_phase = AWAIT_BIT_MARK;
          end
        end else if (!mark && d >= lo_edge(irpwfd_pkg::NOM_SHORT_US)) begin
          bits_seen = bits_seen + 1'b1;
          decided = 1'b1;
          good = (bits_seen == irpwfd_pkg::BITS_12) || (bits_seen == irpwfd_pkg::BITS_15) ||
                 (bits_seen == irpwfd_pkg::BITS_MAX);
        end else begin
          decided = 1'b1;
        end
      end
    endcase
    // burst closes while the frame is still open
    if (!decided && w.burst_end) begin
      decided = 1'b1;
      if (frame_phase == AWAIT_BIT_MARK) begin
        good = (bits_seen == irpwfd_pkg::BITS_12) || (bits_seen == irpwfd_pkg::BITS_15);
      end else if (frame_phase == AWAIT_BIT_SPACE) begin
        bits_seen = bits_seen + 1'b1;
        good = (bits_seen == irpwfd_pkg::BITS_12) || (bits_seen == irpwfd_pkg::BITS_15) ||
               (bits_seen == irpwfd_pkg::BITS_MAX);
      end
    end
    if (!decided) return 1'b0;
    res.frame_valid = good;
    res.code = shift_reg;
    res.bit_count = bits_seen;
    res.matched = good && shift_reg == want_code && bits_seen == want_count;
    if (w.burst_end) begin
      clear_frame();
    end else begin
      frame_phase = AWAIT_BURST_END;
      reported = 1'b1;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- random picks
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DUR_W-1:0] jitter(input int unsigned nom);
    return DUR_W'($urandom_range(lo_edge(nom), hi_edge(nom)));
  endfunction

  function automatic logic [DUR_W-1:0] long_space();
    if ($urandom_range(0, 7) == 0) return '1;
    return DUR_W'(hi_edge(irpwfd_pkg::NOM_SHORT_US) + 1 + $urandom_range(0, 4000));
  endfunction

  // wide spread, with a bias toward the window edges
  function automatic logic [DUR_W-1:0] rand_dur();
    int          v;
    int unsigned nom;
    case ($urandom_range(0, 3))
      0: return DUR_W'($urandom_range(0, 65535));
      1: return DUR_W'($urandom_range(0, 3000));
      default: begin
        case ($urandom_range(0, 2))
          0: nom = irpwfd_pkg::NOM_HDR_MARK_US;
          1: nom = irpwfd_pkg::NOM_SHORT_US;
          default: nom = irpwfd_pkg::NOM_LONG_US;
        endcase
        if ($urandom_range(0, 1)) v = int'(hi_edge(nom));
        else v = int'(lo_edge(nom));
        v = v + int'($urandom_range(0, 2)) - 1;
        if (v < 0) v = 0;
        return DUR_W'(v);
      end
    endcase
  endfunction

  function automatic void add_row(input bit lvl, input int unsigned dur, input bit fin,
                                  input bit zero_result);
    pulse_row_t row;
    row.w.level = lvl;
    row.w.duration_us = DUR_W'(dur);
    row.w.burst_end = fin;
    row.zero_result = zero_result;
    pulse_table.push_back(row);
  endfunction

  // ---------------------------------------------------------------- drivers
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_pulse(input irpwfd_pkg::in_word_t w, input bit zero_result);
    int                    gap;
    bit                    got;
    irpwfd_pkg::out_word_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    pulses_sent++;
    got = decode_pulse(w, res);
    if (zero_result) pending_frames.push_back('0);
    else if (got) pending_frames.push_back(res);
    @(negedge clk);
  endtask

  // result path runs through the input and output registers; a dropped pulse may still be in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [TOL_W-1:0] tol, input logic [CODE_W-1:0] code,
                                input logic [CNT_W-1:0] cnt);
    cfg_wr_en <= 1'b1;
    cfg_index <= irpwfd_pkg::CFG_TOLERANCE;
    cfg_wdata <= CFG_DATA_W'(tol);
    @(negedge clk);
    cfg_index <= irpwfd_pkg::CFG_MATCH_CODE;
    cfg_wdata <= CFG_DATA_W'(code);
    @(negedge clk);
    cfg_index <= irpwfd_pkg::CFG_MATCH_COUNT;
    cfg_wdata <= CFG_DATA_W'(cnt);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tol_pct = tol;
    want_code = code;
    want_count = cnt;
    @(negedge clk);
  endtask

  task automatic send_burst();
    irpwfd_pkg::in_word_t seq[$];
    irpwfd_pkg::in_word_t w;
    int                   kind;
    int                   nbits;
    int                   ending;
    int                   idx;
    logic [CODE_W-1:0]    bits;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      repeat ($urandom_range(1, 6)) begin
        w.level = 1'($urandom_range(0, 1));
        w.duration_us = rand_dur();
        w.burst_end = ($urandom_range(0, 3) == 0);
        seq.push_back(w);
      end
    end else begin
      if ($urandom_range(0, 99) < 70) begin
        case ($urandom_range(0, 2))
          0: nbits = int'(irpwfd_pkg::BITS_12);
          1: nbits = int'(irpwfd_pkg::BITS_15);
          default: nbits = int'(irpwfd_pkg::BITS_MAX);
        endcase
      end else begin
        nbits = $urandom_range(1, 20);
      end
      bits = CODE_W'($urandom);
      ending = $urandom_range(0, 4);
      // steer some frames onto the programmed code
      if ($urandom_range(0, 5) == 0 && want_count >= 1 && want_count <= irpwfd_pkg::BITS_MAX)
      begin
        nbits = int'(want_count);
        bits = want_code;
        ending = 0;
        kind = 99;
      end
      seq.push_back('{level: 1'b1, duration_us: jitter(irpwfd_pkg::NOM_HDR_MARK_US),
                      burst_end: 1'b0});
      seq.push_back('{level: 1'b0, duration_us: jitter(irpwfd_pkg::NOM_SHORT_US),
                      burst_end: 1'b0});
      for (int i = nbits - 1; i >= 0; i--) begin
        seq.push_back('{level: 1'b1,
                        duration_us: jitter(bits[i] ? irpwfd_pkg::NOM_LONG_US :
                                                      irpwfd_pkg::NOM_SHORT_US),
                        burst_end: 1'b0});
        if (i > 0)
          seq.push_back('{level: 1'b0, duration_us: jitter(irpwfd_pkg::NOM_SHORT_US),
                          burst_end: 1'b0});
      end
      case (ending)
        0: seq.push_back('{level: 1'b0, duration_us: long_space(), burst_end: 1'b0});
        1: seq.push_back('{level: 1'b0, duration_us: jitter(irpwfd_pkg::NOM_SHORT_US),
                           burst_end: 1'b0});
        2: ;
        3: begin
          seq.push_back('{level: 1'b0, duration_us: jitter(irpwfd_pkg::NOM_SHORT_US),
                          burst_end: 1'b0});
          seq.push_back('{level: 1'b1,
                          duration_us: DUR_W'($urandom_range(
                                         hi_edge(irpwfd_pkg::NOM_LONG_US) + 1, 65535)),
                          burst_end: 1'b0});
        end
        default: begin
          seq.push_back('{level: 1'b0, duration_us: jitter(irpwfd_pkg::NOM_SHORT_US),
                          burst_end: 1'b0});
          seq.push_back('{level: 1'b0, duration_us: jitter(irpwfd_pkg::NOM_SHORT_US),
                          burst_end: 1'b0});
        end
      endcase
      if (kind < 35) begin
        idx = $urandom_range(0, seq.size() - 1);
        if ($urandom_range(0, 1)) seq[idx].level = ~seq[idx].level;
        else seq[idx].duration_us = rand_dur();
      end
      // junk after the frame; any that follows the decision must be dropped
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          w.level = 1'($urandom_range(0, 1));
          w.duration_us = rand_dur();
          w.burst_end = 1'b0;
          seq.push_back(w);
        end
      end
    end
    seq[seq.size() - 1].burst_end = 1'b1;
    foreach (seq[i]) push_pulse(seq[i], 1'b0);
  endtask

  // ---------------------------------------------------------------- result side
  initial begin
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      steady = ~steady;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_ready <= (stall_left == 0);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        oldest = pending_frames.pop_front();
        check_field("frame_valid", 32'(oldest.frame_valid), 32'(out_data.frame_valid));
        check_field("code", 32'(oldest.code), 32'(out_data.code));
        check_field("bit_count", 32'(oldest.bit_count), 32'(out_data.bit_count));
        check_field("matched", 32'(oldest.matched), 32'(out_data.matched));
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int target;
    int bursts;
    // rows flagged 1 expect an invalid all-zero word
    add_row(1'b0, 2400, 1'b1, 1'b1);   // wrong header level
    add_row(1'b1, 65535, 1'b1, 1'b1);  // saturated duration
    add_row(1'b1, 0, 1'b1, 1'b1);
    add_row(1'b1, 2400, 1'b1, 1'b1);   // burst ends on the header mark
    add_row(1'b1, 2400, 1'b0, 1'b0);
    add_row(1'b0, 600, 1'b1, 1'b1);    // burst ends before first bit
    add_row(1'b0, 100, 1'b0, 1'b1);    // header mismatch, then ignored words
    add_row(1'b1, 2400, 1'b0, 1'b0);
    add_row(1'b0, 600, 1'b1, 1'b0);
    add_row(1'b1, 2400, 1'b0, 1'b0);   // two bits, long space
    add_row(1'b0, 600, 1'b0, 1'b0);
    add_row(1'b1, 1200, 1'b0, 1'b0);
    add_row(1'b0, 600, 1'b0, 1'b0);
    add_row(1'b1, 600, 1'b0, 1'b0);
    add_row(1'b0, 5000, 1'b1, 1'b0);
    add_row(1'b1, 2400, 1'b0, 1'b0);   // mark where a space belongs
    add_row(1'b0, 600, 1'b0, 1'b0);
    add_row(1'b1, 1200, 1'b0, 1'b0);
    add_row(1'b1, 1200, 1'b1, 1'b0);
    add_row(1'b1, 2400, 1'b0, 1'b0);   // bit mark out of both windows
    add_row(1'b0, 600, 1'b0, 1'b0);
    add_row(1'b1, 1200, 1'b0, 1'b0);
    add_row(1'b0, 600, 1'b0, 1'b0);
    add_row(1'b1, 3000, 1'b1, 1'b0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (pulse_table[i]) push_pulse(pulse_table[i].w, pulse_table[i].zero_result);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        0: apply_settings(7'd0, CODE_W'($urandom_range(0, 4095)), irpwfd_pkg::BITS_12);
        1: apply_settings(7'd100, CODE_W'($urandom_range(0, 32767)), irpwfd_pkg::BITS_15);
        2: apply_settings(7'd127, '1, irpwfd_pkg::BITS_MAX);
        3: apply_settings(7'd10, '0, 5'd0);
        4: apply_settings(7'd50, CODE_W'($urandom), 5'd31);
        default: apply_settings(TOL_W'($urandom_range(1, 99)),
                                CODE_W'($urandom_range(0, 4095)), irpwfd_pkg::BITS_12);
      endcase
      target = pulses_sent + 130;
      bursts = 0;
      while (pulses_sent < target || bursts < 8) begin
        send_burst();
        bursts++;
      end
    end
    in_valid <= 1'b0;

    while (pending_frames.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("ir_pulse_width_frame_decoder_unit verification clean");
    end else begin
      $display("ir_pulse_width_frame_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
